/* rtl/core/rle_sprite_pixel_alpha_lookup_defines.svh */
// Assertion macros shared by the sprite alpha lookup RTL.
`ifndef RLE_SPRITE_PIXEL_ALPHA_LOOKUP_DEFINES_SVH
`define RLE_SPRITE_PIXEL_ALPHA_LOOKUP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RSAL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsal: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define RSAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsal: next-cycle check failed");

`endif

/* rtl/core/rsal_pkg.sv */
// Shared types and constants for the sprite alpha lookup block.
package rsal_pkg;

  // Field widths of the stream beats.
  localparam int unsigned CoordW = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned InDataW  = 2 * CoordW + ByteW;
  localparam int unsigned OutDataW = ByteW;

  // Configuration port.
  localparam int unsigned AddrW = 4;
  localparam int unsigned ApbDataW = 32;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_FRAME_OFFSET_X = 2'd2,
    REG_FRAME_OFFSET_Y = 2'd3
  } reg_idx_t;

  // Beat kind carried on the input tuser bit.
  typedef enum logic {
    MODE_START = 1'b0,
    MODE_BYTE  = 1'b1
  } mode_t;

endpackage

/* rtl/core/rle_sprite_pixel_alpha_lookup.sv */
// Pixel alpha lookup over a run-length coded sprite frame stream.
//
// Usage: program frame_width, frame_height and the signed offsets over the APB
// port (byte addresses 0, 4, 8, 12) while the block is idle. On the input
// stream, a beat with tuser 0 is a start that carries the query point; a beat
// with tuser 1 carries one byte of the coded frame. The output stream returns
// one beat per query: tdata holds the alpha, tuser says whether the point lay
// inside the frame. A point outside answers right after its start beat;
// otherwise the answer follows the alpha byte of the run covering the pixel,
// and later bytes are dropped until the next start.
// Timing: one input beat per cycle while the output register is free (see Stall).
// Each beat is decoded by the counters and compares between the input side and a
// single output register, so a result appears in the cycle after the beat that causes it.
// Stall: while a result waits in the output register and m_tready is low,
// s_tready is low too; the input side moves as soon as the register drains.
// Reset: rst clears the configuration registers, the walk state (no query
// pending) and the output valid flag.
module rle_sprite_pixel_alpha_lookup (
  input  logic                           clk,
  input  logic                           rst,
  // Input stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rsal_pkg::InDataW-1:0]   s_tdata,  // query_x, query_y, data_byte
  input  logic                           s_tuser,  // mode
  // Result stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rsal_pkg::OutDataW-1:0]  m_tdata,  // alpha
  output logic                           m_tuser,  // inside_res
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rsal_pkg::AddrW-1:0]     paddr,
  input  logic [rsal_pkg::ApbDataW-1:0]  pwdata,
  output logic [rsal_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import rsal_pkg::*;

  `include "rle_sprite_pixel_alpha_lookup_defines.svh"

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COUNT,
    PH_ALPHA,
    PH_SKIP
  } phase_t;

  // Configuration registers.
  logic [CoordW-1:0] frame_width;
  logic [CoordW-1:0] frame_height;
  logic [CoordW-1:0] frame_offset_x;
  logic [CoordW-1:0] frame_offset_y;

  // Walk state.
  phase_t            phase, phase_next;
  logic [CoordW-1:0] lines_left, lines_left_next;
  logic [CoordW+1:0] pixels_left, pixels_left_next;
  logic [ByteW-1:0]  run_length, run_length_next;
  logic [ByteW-1:0]  skip_left, skip_left_next;
  logic              on_target_line, on_target_line_next;
  logic [CoordW:0]   target_col, target_col_next;

  // Result staging.
  logic              emit;
  logic [ByteW-1:0]  emit_alpha;
  logic              emit_inside;

  logic              s_accept;
  logic              cfg_write;
  reg_idx_t          reg_idx;

  logic [CoordW-1:0] query_x, query_y;
  logic [ByteW-1:0]  data_byte;
  logic [CoordW:0]   pos_x, pos_y;
  logic              point_inside;
  logic              run_ends;
  logic [CoordW-1:0] lines_dec;

  assign query_x   = s_tdata[CoordW-1:0];
  assign query_y   = s_tdata[2*CoordW-1:CoordW];
  assign data_byte = s_tdata[InDataW-1:2*CoordW];

  // The input moves whenever the output register is empty or draining.
  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  // APB access, always ready.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = reg_idx_t'(paddr[AddrW-1:2]);

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:    prdata = {{(ApbDataW-CoordW){1'b0}}, frame_width};
      REG_FRAME_HEIGHT:   prdata = {{(ApbDataW-CoordW){1'b0}}, frame_height};
      REG_FRAME_OFFSET_X: prdata = {{(ApbDataW-CoordW){1'b0}}, frame_offset_x};
      REG_FRAME_OFFSET_Y: prdata = {{(ApbDataW-CoordW){1'b0}}, frame_offset_y};
      default:            prdata = '0;
    endcase
  end

  // Query point relative to the frame, 17-bit signed.
  assign pos_x = {query_x[CoordW-1], query_x} - {frame_offset_x[CoordW-1], frame_offset_x};
  assign pos_y = {query_y[CoordW-1], query_y} - {frame_offset_y[CoordW-1], frame_offset_y};
  assign point_inside = !pos_x[CoordW] && (pos_x[CoordW-1:0] < frame_width) &&
                        !pos_y[CoordW] && (pos_y[CoordW-1:0] < frame_height);

  assign run_ends  = {{(CoordW+2-ByteW){1'b0}}, run_length} >= pixels_left;
  assign lines_dec = lines_left - 1'b1;

  // Per-beat decode of the walk.
  always_comb begin
    phase_next          = phase;
    lines_left_next     = lines_left;
    pixels_left_next    = pixels_left;
    run_length_next     = run_length;
    skip_left_next      = skip_left;
    on_target_line_next = on_target_line;
    target_col_next     = target_col;
    emit                = 1'b0;
    emit_alpha          = '0;
    emit_inside         = 1'b0;

    if (mode_t'(s_tuser) == MODE_START) begin
      if (!point_inside) begin
        phase_next = PH_IDLE;
        emit       = 1'b1;
      end else begin
        target_col_next     = {1'b0, pos_x[CoordW-1:0]} + 1'b1;
        lines_left_next     = pos_y[CoordW-1:0];
        on_target_line_next = (pos_y[CoordW-1:0] == '0);
        pixels_left_next    = (pos_y[CoordW-1:0] == '0)
                              ? {1'b0, target_col_next}
                              : {2'b00, frame_width};
        run_length_next     = '0;
        skip_left_next      = '0;
        phase_next          = PH_COUNT;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          // Stray bytes are ignored.
        end
        PH_COUNT: begin
          run_length_next = data_byte;
          phase_next      = PH_ALPHA;
        end
        PH_ALPHA: begin
          if (run_ends && on_target_line) begin
            phase_next  = PH_IDLE;
            emit        = 1'b1;
            emit_alpha  = data_byte;
            emit_inside = 1'b1;
          end else begin
            if (run_ends) begin
              // The run closes this line; the excess is not carried over.
              lines_left_next = lines_dec;
              if (lines_dec == '0) begin
                on_target_line_next = 1'b1;
                pixels_left_next    = {1'b0, target_col};
              end else begin
                pixels_left_next = {2'b00, frame_width};
              end
            end else begin
              pixels_left_next = pixels_left - {{(CoordW+2-ByteW){1'b0}}, run_length};
            end
            // Opaque runs are followed by their pixel bytes.
            if (data_byte != '0 && run_length != '0) begin
              skip_left_next = run_length;
              phase_next     = PH_SKIP;
            end else begin
              phase_next = PH_COUNT;
            end
          end
        end
        PH_SKIP: begin
          skip_left_next = skip_left - 1'b1;
          if (skip_left_next == '0) begin
            phase_next = PH_COUNT;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= '0;
      frame_height   <= '0;
      frame_offset_x <= '0;
      frame_offset_y <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:    frame_width    <= pwdata[CoordW-1:0];
        REG_FRAME_HEIGHT:   frame_height   <= pwdata[CoordW-1:0];
        REG_FRAME_OFFSET_X: frame_offset_x <= pwdata[CoordW-1:0];
        REG_FRAME_OFFSET_Y: frame_offset_y <= pwdata[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // Walk state, advanced once per accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      lines_left     <= '0;
      pixels_left    <= '0;
      run_length     <= '0;
      skip_left      <= '0;
      on_target_line <= 1'b0;
      target_col     <= '0;
    end else if (s_accept) begin
      phase          <= phase_next;
      lines_left     <= lines_left_next;
      pixels_left    <= pixels_left_next;
      run_length     <= run_length_next;
      skip_left      <= skip_left_next;
      on_target_line <= on_target_line_next;
      target_col     <= target_col_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && emit) begin
      m_tdata <= emit_alpha;
      m_tuser <= emit_inside;
    end
  end

  // A point outside the frame always reports alpha zero.
  `RSAL_ASSERT_NOW(a_outside_zero, m_tvalid && !m_tuser, m_tdata == '0)
  // An out-of-frame start answers on the next cycle.
  `RSAL_ASSERT_NEXT(a_outside_answers,
      s_accept && mode_t'(s_tuser) == MODE_START && !point_inside,
      m_tvalid && !m_tuser)
  // Emitting an inside result ends the query.
  `RSAL_ASSERT_NEXT(a_emit_idles, s_accept && emit && emit_inside, phase == PH_IDLE)
  // Skipping pixel bytes always has a nonzero count left.
  `RSAL_ASSERT_NOW(a_skip_nonzero, phase == PH_SKIP, skip_left != '0)

endmodule
